// File: hw/rtl/dlpd_pkg.sv
// Package: shared types and constants for the debounced long-press detector.
`timescale 1ns / 1ps
`default_nettype none

package dlpd_pkg;

    // Action codes of an input transaction
    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_POLL = 2'd1;
    localparam logic [1:0] ACT_EDGE = 2'd2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_RELEASE  = 2'd2;

    // Register reset values in milliseconds
    localparam logic [15:0] DEBOUNCE_RST = 16'd40;
    localparam logic [15:0] HOLD_RST     = 16'd2000;
    localparam logic [15:0] RELEASE_RST  = 16'd150;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        pressed;
    } t_in_item;

    typedef struct packed {
        logic        shutdown_request;
        logic        raw_level;
        logic        stable_level;
        logic        armed_flag;
        logic [31:0] trigger_total;
        logic [31:0] edge_total;
    } t_out_item;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] hold_time;
        logic [15:0] release_time;
    } t_cfg;

endpackage : dlpd_pkg

`default_nettype wire

// File: hw/rtl/dlpd_cfg.sv
// APB-style configuration registers for the debounced long-press detector.
`timescale 1ns / 1ps
`default_nettype none

module dlpd_cfg
    import dlpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // Write a register on the access cycle; ignore addresses beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= DEBOUNCE_RST;
            r_cfg.hold_time     <= HOLD_RST;
            r_cfg.release_time  <= RELEASE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEBOUNCE: r_cfg.debounce_time <= pwdata[15:0];
                REG_HOLD:     r_cfg.hold_time     <= pwdata[15:0];
                REG_RELEASE:  r_cfg.release_time  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_DEBOUNCE: prdata = {16'd0, r_cfg.debounce_time};
            REG_HOLD:     prdata = {16'd0, r_cfg.hold_time};
            REG_RELEASE:  prdata = {16'd0, r_cfg.release_time};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule : dlpd_cfg

`default_nettype wire

// File: hw/rtl/dlpd_state.sv
// Detector state registers and the single-pass update for one transaction.
`timescale 1ns / 1ps
`default_nettype none

module dlpd_state
    import dlpd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_out_item     o_result
);

    logic        r_last_raw,      n_last_raw;
    logic        r_stable,        n_stable;
    logic [31:0] r_raw_stamp,     n_raw_stamp;
    logic [31:0] r_press_stamp,   n_press_stamp;
    logic [31:0] r_release_stamp, n_release_stamp;
    logic        r_armed,         n_armed;
    logic [31:0] r_trig_cnt,      n_trig_cnt;
    logic [31:0] r_edge_cnt,      n_edge_cnt;
    logic        n_req;

    logic [31:0] w_raw_age;
    logic [31:0] w_press_age;
    logic [31:0] w_release_age;
    logic [31:0] w_poll_raw_stamp;
    logic        w_settled;
    logic        w_stable;
    logic [31:0] w_press_stamp;
    logic [31:0] w_release_stamp;

    // Poll path: restart debounce timer, adopt stable level, test hold and release
    always_comb begin
        w_poll_raw_stamp = (i_item.pressed != r_last_raw) ? i_item.now_ms : r_raw_stamp;
        w_raw_age        = i_item.now_ms - w_poll_raw_stamp;
        w_settled        = (i_item.pressed != r_stable) &&
                           (w_raw_age >= {16'd0, i_cfg.debounce_time});
        w_stable         = w_settled ? i_item.pressed : r_stable;
        w_press_stamp    = (w_settled && i_item.pressed) ? i_item.now_ms : r_press_stamp;
        if (w_settled) begin
            w_release_stamp = i_item.pressed ? 32'd0 : i_item.now_ms;
        end else begin
            w_release_stamp = r_release_stamp;
        end
        w_press_age   = i_item.now_ms - w_press_stamp;
        w_release_age = i_item.now_ms - w_release_stamp;
    end

    // Select next state by action
    always_comb begin
        n_last_raw      = r_last_raw;
        n_stable        = r_stable;
        n_raw_stamp     = r_raw_stamp;
        n_press_stamp   = r_press_stamp;
        n_release_stamp = r_release_stamp;
        n_armed         = r_armed;
        n_trig_cnt      = r_trig_cnt;
        n_edge_cnt      = r_edge_cnt;
        n_req           = 1'b0;
        unique case (i_item.action)
            ACT_INIT: begin
                n_last_raw      = i_item.pressed;
                n_stable        = i_item.pressed;
                n_raw_stamp     = i_item.now_ms;
                n_press_stamp   = i_item.now_ms;
                n_release_stamp = i_item.now_ms;
                n_armed         = !i_item.pressed;
            end
            ACT_POLL: begin
                n_last_raw      = i_item.pressed;
                n_stable        = w_stable;
                n_raw_stamp     = w_poll_raw_stamp;
                n_press_stamp   = w_press_stamp;
                n_release_stamp = w_release_stamp;
                if (w_stable && r_armed && (w_press_age >= {16'd0, i_cfg.hold_time})) begin
                    n_armed    = 1'b0;
                    n_trig_cnt = r_trig_cnt + 32'd1;
                    n_req      = 1'b1;
                end else if (!w_stable && !r_armed && (w_release_stamp != 32'd0) &&
                             (w_release_age >= {16'd0, i_cfg.release_time})) begin
                    n_armed = 1'b1;
                end
            end
            ACT_EDGE: begin
                n_edge_cnt = r_edge_cnt + 32'd1;
            end
            default: ;
        endcase
    end

    // Hold state; advance on each transaction taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw      <= 1'b0;
            r_stable        <= 1'b0;
            r_raw_stamp     <= '0;
            r_press_stamp   <= '0;
            r_release_stamp <= '0;
            r_armed         <= 1'b0;
            r_trig_cnt      <= '0;
            r_edge_cnt      <= '0;
        end else if (i_step) begin
            r_last_raw      <= n_last_raw;
            r_stable        <= n_stable;
            r_raw_stamp     <= n_raw_stamp;
            r_press_stamp   <= n_press_stamp;
            r_release_stamp <= n_release_stamp;
            r_armed         <= n_armed;
            r_trig_cnt      <= n_trig_cnt;
            r_edge_cnt      <= n_edge_cnt;
        end
    end

    assign o_result.shutdown_request = n_req;
    assign o_result.raw_level        = n_last_raw;
    assign o_result.stable_level     = n_stable;
    assign o_result.armed_flag       = n_armed;
    assign o_result.trigger_total    = n_trig_cnt;
    assign o_result.edge_total       = n_edge_cnt;

endmodule : dlpd_state

`default_nettype wire

// File: hw/rtl/debounced_long_press_detector.sv
// Top level: debounced long-press detector for one button.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one transaction
// per button event: init capture, poll step or edge note, with a millisecond
// timestamp and the sampled pressed level. Output channel (o_out_valid /
// i_out_stall / o_out_data) returns exactly one result per input transaction,
// in order. A transaction is taken at a clock edge with valid high, stall low.
// Each result passes through one input register, then the state update and
// result register. Throughput is one transaction per cycle while the receiver
// does not stall; the next transaction may be taken while a result waits.
// When the receiver stalls, the result register holds; the input register
// still fills, and o_in_stall rises only while both registers are occupied.
// Synchronous reset clears both pipeline registers, the detector state
// (disarmed until init) and both counters, and restores the register defaults
// (debounce 40 ms, hold 2000 ms, release 150 ms).
// Registers sit at APB byte addresses 0, 4 and 8; write them while idle.
`timescale 1ns / 1ps
`default_nettype none

module debounced_long_press_detector
    import dlpd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_advance;

    dlpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Move a transaction to the result register when it is free or draining
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_advance  = r_in_vld && w_out_free;
    assign o_in_stall = r_in_vld && !w_out_free;

    dlpd_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Input register: load whenever not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule : debounced_long_press_detector

`default_nettype wire
